FILE: hdl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cau_pkg.sv
// Types, constants and arithmetic helpers of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int TOL_W         = 17;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 65;
  localparam int QUO_W         = 33;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = 17'd1;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_NEG = 3'd4;
  localparam logic [OP_W-1:0] OP_CMP = 3'd5;

  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              eq;
    logic              dz;
    logic              sat;
  } res_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic [QUO_W-1:0]  feed;
  } div_t;

  typedef struct packed {
    logic is_div;
    logic ovf_re;
    logic ovf_im;
    logic neg_re;
    logic neg_im;
    res_t res;
  } ctl_t;

  // Clamp a sign-magnitude value; returns {sat, value}.
  function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
    logic [PROD_W-1:0] n;
    n = -mag;
    if (neg) begin
      if (mag > PROD_W'(NEG_MIN)) return {1'b1, NEG_MIN};
      return {1'b0, n[DATA_W-1:0]};
    end
    if (mag > PROD_W'(POS_MAX)) return {1'b1, POS_MAX};
    return {1'b0, mag[DATA_W-1:0]};
  endfunction

  // Clamp a 33-bit two's complement value; returns {sat, value}.
  function automatic logic [DATA_W:0] sat_s33(input logic [DATA_W:0] s);
    if (s[DATA_W] != s[DATA_W-1]) begin
      if (s[DATA_W]) return {1'b1, NEG_MIN};
      return {1'b1, POS_MAX};
    end
    return {1'b0, s[DATA_W-1:0]};
  endfunction

  // One restoring division step: one quotient bit.
  function automatic div_t div_step(input div_t d, input logic [PROD_W-1:0] den);
    logic [PROD_W:0] t;
    logic [PROD_W:0] diff;
    div_t o;
    t    = {d.rem, d.feed[QUO_W-1]};
    diff = t - {1'b0, den};
    o.feed = {d.feed[QUO_W-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      o.rem = diff[PROD_W-1:0];
      o.quo = {d.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[PROD_W-1:0];
      o.quo = {d.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: add, sub, mul, div, negate and compare pipeline.
// One item can enter every cycle while in_stall is low. The pipeline has four stages
// of products, sums, magnitudes and division setup, followed by 33 pipelined
// restoring divider stages, one quotient bit each. All ops run through the same
// pipeline, so results leave in input order. A one-entry skid register behind the
// output register drives in_stall, so a stall at the output reaches the input once
// an item is caught in the skid register. equal_tolerance resets to 1.
`default_nettype none

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic        [cau_pkg::TOL_W-1:0]      cfg_data,
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic        [cau_pkg::OP_W-1:0]       op,
  input  wire logic signed [cau_pkg::DATA_W-1:0]     a_re,
  input  wire logic signed [cau_pkg::DATA_W-1:0]     a_im,
  input  wire logic signed [cau_pkg::DATA_W-1:0]     b_re,
  input  wire logic signed [cau_pkg::DATA_W-1:0]     b_im,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic signed [cau_pkg::DATA_W-1:0]     res_re,
  output      logic signed [cau_pkg::DATA_W-1:0]     res_im,
  output      logic                                  is_equal,
  output      logic                                  div_zero,
  output      logic                                  saturated
);
  import cau_pkg::*;

  `include "assert_macros.svh"

  localparam int NUM_W = PROD_W + FRAC_BITS;
  localparam int HI_W  = NUM_W - QUO_W;

  logic [TOL_W-1:0] equal_tolerance;
  logic             en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      equal_tolerance <= cfg_data;
    end
  end

  // stage 1: products and short ops
  logic [DATA_W:0] add_re, add_im, sub_re, sub_im, ng_re, ng_im;
  logic [DATA_W:0] abs_re, abs_im;
  logic [DATA_W:0] sat_re, sat_im;
  res_t            simple;

  always_comb begin
    add_re = {a_re[DATA_W-1], a_re} + {b_re[DATA_W-1], b_re};
    add_im = {a_im[DATA_W-1], a_im} + {b_im[DATA_W-1], b_im};
    sub_re = {a_re[DATA_W-1], a_re} - {b_re[DATA_W-1], b_re};
    sub_im = {a_im[DATA_W-1], a_im} - {b_im[DATA_W-1], b_im};
    ng_re  = -{a_re[DATA_W-1], a_re};
    ng_im  = -{a_im[DATA_W-1], a_im};
    abs_re = sub_re[DATA_W] ? -sub_re : sub_re;
    abs_im = sub_im[DATA_W] ? -sub_im : sub_im;
    simple = '0;
    sat_re = '0;
    sat_im = '0;
    case (op)
      OP_ADD: begin
        sat_re = sat_s33(add_re);
        sat_im = sat_s33(add_im);
      end
      OP_SUB: begin
        sat_re = sat_s33(sub_re);
        sat_im = sat_s33(sub_im);
      end
      OP_NEG: begin
        sat_re = sat_s33(ng_re);
        sat_im = sat_s33(ng_im);
      end
      OP_CMP: begin
        simple.eq = (abs_re < (DATA_W+1)'(equal_tolerance)) &&
                    (abs_im < (DATA_W+1)'(equal_tolerance));
      end
      default: begin
        simple.eq = 1'b0;
      end
    endcase
    simple.re  = sat_re[DATA_W-1:0];
    simple.im  = sat_im[DATA_W-1:0];
    simple.sat = sat_re[DATA_W] | sat_im[DATA_W];
  end

  logic                     v1;
  logic [OP_W-1:0]          op1;
  logic signed [PROD_W-1:0] prr1, pii1, pri1, pir1, pbr1, pbi1;
  res_t                     res1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= op;
      prr1 <= a_re * b_re;
      pii1 <= a_im * b_im;
      pri1 <= a_re * b_im;
      pir1 <= a_im * b_re;
      pbr1 <= b_re * b_re;
      pbi1 <= b_im * b_im;
      res1 <= simple;
    end
  end

  // stage 2: wide sums
  logic              v2;
  logic [OP_W-1:0]   op2;
  logic [SUM_W-1:0]  num_re2, num_im2;
  logic [PROD_W-1:0] den2;
  res_t              res2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2  <= op1;
      den2 <= $unsigned(pbr1) + $unsigned(pbi1);
      res2 <= res1;
      if (op1 == OP_DIV) begin
        num_re2 <= {prr1[PROD_W-1], prr1} + {pii1[PROD_W-1], pii1};
        num_im2 <= {pir1[PROD_W-1], pir1} - {pri1[PROD_W-1], pri1};
      end else begin
        num_re2 <= {prr1[PROD_W-1], prr1} - {pii1[PROD_W-1], pii1};
        num_im2 <= {pri1[PROD_W-1], pri1} + {pir1[PROD_W-1], pir1};
      end
    end
  end

  // stage 3: sign and magnitude
  logic              v3;
  logic [OP_W-1:0]   op3;
  logic              neg_re3, neg_im3;
  logic [PROD_W-1:0] mag_re3, mag_im3, den3;
  res_t              res3;
  logic [SUM_W-1:0]  abs2_re, abs2_im;

  assign abs2_re = num_re2[SUM_W-1] ? -num_re2 : num_re2;
  assign abs2_im = num_im2[SUM_W-1] ? -num_im2 : num_im2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3     <= op2;
      neg_re3 <= num_re2[SUM_W-1];
      neg_im3 <= num_im2[SUM_W-1];
      mag_re3 <= abs2_re[PROD_W-1:0];
      mag_im3 <= abs2_im[PROD_W-1:0];
      den3    <= den2;
      res3    <= res2;
    end
  end

  // stage 4: multiply result and division setup
  logic [NUM_W-1:0]  nw_re, nw_im;
  logic [HI_W-1:0]   hi_re, hi_im;
  logic [DATA_W:0]   ms_re, ms_im;
  ctl_t              ctl4;
  div_t              dre4, dim4;

  always_comb begin
    nw_re = {mag_re3, {FRAC_BITS{1'b0}}};
    nw_im = {mag_im3, {FRAC_BITS{1'b0}}};
    hi_re = nw_re[NUM_W-1:QUO_W];
    hi_im = nw_im[NUM_W-1:QUO_W];
    ms_re = sat_mag(neg_re3, mag_re3 >> FRAC_BITS);
    ms_im = sat_mag(neg_im3, mag_im3 >> FRAC_BITS);
    dre4.rem  = PROD_W'(hi_re);
    dre4.quo  = '0;
    dre4.feed = nw_re[QUO_W-1:0];
    dim4.rem  = PROD_W'(hi_im);
    dim4.quo  = '0;
    dim4.feed = nw_im[QUO_W-1:0];
    ctl4.is_div = (op3 == OP_DIV);
    ctl4.ovf_re = PROD_W'(hi_re) >= den3;
    ctl4.ovf_im = PROD_W'(hi_im) >= den3;
    ctl4.neg_re = neg_re3;
    ctl4.neg_im = neg_im3;
    ctl4.res    = res3;
    if (op3 == OP_MUL) begin
      ctl4.res.re  = ms_re[DATA_W-1:0];
      ctl4.res.im  = ms_im[DATA_W-1:0];
      ctl4.res.sat = ms_re[DATA_W] | ms_im[DATA_W];
    end else if (op3 == OP_DIV) begin
      ctl4.res    = '0;
      ctl4.res.dz = (den3 == '0);
    end
  end

  logic              vs  [QUO_W+1];
  ctl_t              ctl [QUO_W+1];
  logic [PROD_W-1:0] den [QUO_W+1];
  div_t              dre [QUO_W+1];
  div_t              dim [QUO_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= ctl4;
      den[0] <= den3;
      dre[0] <= dre4;
      dim[0] <= dim4;
    end
  end

  // quotient pipeline, one bit per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (en) begin
        vs[k+1] <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[k+1] <= ctl[k];
        den[k+1] <= den[k];
        dre[k+1] <= div_step(dre[k], den[k]);
        dim[k+1] <= div_step(dim[k], den[k]);
      end
    end
  end

  // final clamp and select
  ctl_t            last;
  res_t            fin;
  logic [DATA_W:0] ds_re, ds_im;

  always_comb begin
    last  = ctl[QUO_W];
    ds_re = sat_mag(last.neg_re, last.ovf_re ? '1 : PROD_W'(dre[QUO_W].quo));
    ds_im = sat_mag(last.neg_im, last.ovf_im ? '1 : PROD_W'(dim[QUO_W].quo));
    fin   = last.res;
    if (last.is_div && !last.res.dz) begin
      fin.re  = ds_re[DATA_W-1:0];
      fin.im  = ds_im[DATA_W-1:0];
      fin.sat = ds_re[DATA_W] | ds_im[DATA_W];
    end
  end

  // output register and skid
  logic o_v, skid_v, o_take;
  res_t o_res, skid_res;

  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign o_take   = o_v && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v    <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (o_take) begin
        o_res  <= skid_res;
        skid_v <= 1'b0;
      end
    end else if (vs[QUO_W]) begin
      if (!o_v || o_take) begin
        o_res <= fin;
        o_v   <= 1'b1;
      end else begin
        skid_res <= fin;
        skid_v   <= 1'b1;
      end
    end else if (o_take) begin
      o_v <= 1'b0;
    end
  end

  assign out_valid = o_v;
  assign res_re    = o_res.re;
  assign res_im    = o_res.im;
  assign is_equal  = o_res.eq;
  assign div_zero  = o_res.dz;
  assign saturated = o_res.sat;

  `ASSERT_IMP(a_skid_behind_out, skid_v, o_v, "skid holds an item while output is empty")
  `ASSERT_IMP(a_dz_zero, o_v && o_res.dz, o_res.re == '0 && o_res.im == '0 && !o_res.sat && !o_res.eq, "divide by zero result not cleared")
  `ASSERT_NXT(a_freeze, skid_v, $stable(vs[QUO_W]), "pipeline moved while skid full")
  `ASSERT_NXT(a_skid_fill, !skid_v && vs[QUO_W] && o_v && out_stall, skid_v, "item lost at output")

endmodule

`default_nettype wire

FILE: sim/tb_complex_arithmetic_unit.sv
// Self-checking testbench for the complex arithmetic unit: directed table, random items, scoreboard.
`default_nettype none

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 970;
  localparam logic [OP_W-1:0] OP_NONE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_NONE7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [31:0] a_re, a_im, b_re, b_im;
  } operands_t;

  typedef struct packed {
    logic [31:0] re, im;
    logic eq, dz, sat;
  } outcome_t;

  typedef struct {
    operands_t x;
    bit typed;
    outcome_t want;
  } row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [TOL_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [OP_W-1:0] op;
  logic signed [31:0] a_re, a_im, b_re, b_im;
  logic out_valid, out_stall;
  logic signed [31:0] res_re, res_im;
  logic is_equal, div_zero, saturated;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_re(res_re), .res_im(res_im),
    .is_equal(is_equal), .div_zero(div_zero), .saturated(saturated)
  );

  outcome_t expected_results[$];
  logic [TOL_W-1:0] tolerance;
  int errors = 0;
  int cycles = 0;
  bit long_hold = 0;
  bit burst = 0;
  bit stim_done = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] clamp_wide(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Truncating division toward zero on magnitudes.
  function automatic logic signed [127:0] quot_tz(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
    logic signed [127:0] q;
    q = (n < 0 ? -n : n) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic outcome_t complex_result(input operands_t x, input logic [TOL_W-1:0] tol);
    logic signed [127:0] ar, ai, br, bi, den, nr, ni, dr, di;
    outcome_t r;
    ar = $signed(x.a_re); ai = $signed(x.a_im);
    br = $signed(x.b_re); bi = $signed(x.b_im);
    r = '{re: 0, im: 0, eq: 0, dz: 0, sat: 0};
    case (x.op)
      OP_ADD: begin
        r.re = clamp_wide(ar + br, r.sat);
        r.im = clamp_wide(ai + bi, r.sat);
      end
      OP_SUB: begin
        r.re = clamp_wide(ar - br, r.sat);
        r.im = clamp_wide(ai - bi, r.sat);
      end
      OP_MUL: begin
        nr = ar * br - ai * bi;
        ni = ar * bi + ai * br;
        r.re = clamp_wide(quot_tz(nr, 128'sd65536), r.sat);
        r.im = clamp_wide(quot_tz(ni, 128'sd65536), r.sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1;
        else begin
          nr = (ar * br + ai * bi) * 65536;
          ni = (ai * br - ar * bi) * 65536;
          r.re = clamp_wide(quot_tz(nr, den), r.sat);
          r.im = clamp_wide(quot_tz(ni, den), r.sat);
        end
      end
      OP_NEG: begin
        r.re = clamp_wide(-ar, r.sat);
        r.im = clamp_wide(-ai, r.sat);
      end
      OP_CMP: begin
        dr = ar - br; di = ai - bi;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        r.eq = (dr < tol) && (di < tol);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      2: return $urandom_range(0, 4) - 2;
      3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic operands_t random_operands();
    operands_t x;
    x.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    x.a_re = rand_part(); x.a_im = rand_part();
    x.b_re = rand_part(); x.b_im = rand_part();
    if (x.op == OP_CMP && $urandom_range(0, 1)) begin
      x.b_re = x.a_re + $urandom_range(0, 6) - 3;
      x.b_im = x.a_im + $urandom_range(0, 6) - 3;
    end
    if (x.op == OP_DIV && $urandom_range(0, 9) == 0) begin
      x.b_re = 0; x.b_im = 0;
    end
    return x;
  endfunction

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    tolerance = v;
  endtask

  task automatic send_item(input operands_t x, input bit typed, input outcome_t want);
    outcome_t e;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (burst) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    e = complex_result(x, tolerance);
    if (typed && e != want) begin
      $error("table row disagrees with predictor for op %0d", x.op);
      errors++;
    end
    in_valid <= 1;
    op <= x.op; a_re <= x.a_re; a_im <= x.a_im; b_re <= x.b_re; b_im <= x.b_im;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(typed ? want : e);
  endtask

  task automatic drain();
    in_valid <= 0;
    wait (expected_results.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Output side: random stall per item, plus one long hold-off.
  initial begin
    int hold;
    out_stall = 1;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        w = expected_results.pop_front();
        if (res_re !== w.re) begin
          $error("res_re expected %h actual %h", w.re, res_re); errors++;
        end
        if (res_im !== w.im) begin
          $error("res_im expected %h actual %h", w.im, res_im); errors++;
        end
        if (is_equal !== w.eq) begin
          $error("is_equal expected %b actual %b", w.eq, is_equal); errors++;
        end
        if (div_zero !== w.dz) begin
          $error("div_zero expected %b actual %b", w.dz, div_zero); errors++;
        end
        if (saturated !== w.sat) begin
          $error("saturated expected %b actual %b", w.sat, saturated); errors++;
        end
      end
    end
  end

  row_t directed[$];
  localparam logic [31:0] MX = 32'h7FFF_FFFF;
  localparam logic [31:0] MN = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  function automatic row_t row(input logic [OP_W-1:0] o, input logic [31:0] ar, ai, br, bi,
                               input bit typed = 0, input logic [31:0] rr = 0, ri = 0,
                               input logic e = 0, dz = 0, s = 0);
    row_t r;
    r.x = '{op: o, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    r.typed = typed;
    r.want = '{re: rr, im: ri, eq: e, dz: dz, sat: s};
    return r;
  endfunction

  initial begin
    outcome_t none;
    logic [TOL_W-1:0] tols[5];
    none = '{re: 0, im: 0, eq: 0, dz: 0, sat: 0};
    tols = '{17'd65536, 17'd0, 17'd3, 17'd1, 17'd200};
    rst = 1;
    cfg_valid = 0; cfg_data = 0; in_valid = 0;
    op = 0; a_re = 0; a_im = 0; b_re = 0; b_im = 0;
    tolerance = TOL_RESET;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    directed.push_back(row(OP_ADD, MX, MN, 1, MN, 1, MX, MN, 0, 0, 1));
    directed.push_back(row(OP_ADD, ONE, 2, ONE, 3, 1, 32'h0002_0000, 5));
    directed.push_back(row(OP_SUB, MN, MX, 1, MN, 1, MN, MX, 0, 0, 1));
    directed.push_back(row(OP_SUB, 5, 5, 5, 5, 1, 0, 0));
    directed.push_back(row(OP_MUL, ONE, ONE, ONE, ONE, 1, 0, 32'h0002_0000));
    directed.push_back(row(OP_MUL, MN, MN, MN, MN));
    directed.push_back(row(OP_MUL, MX, MX, MX, MN));
    directed.push_back(row(OP_MUL, 32'hFFFF_FFFF, 0, 1, 0, 1, 0, 0));
    directed.push_back(row(OP_DIV, ONE, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed.push_back(row(OP_DIV, ONE, ONE, ONE, 0, 1, ONE, ONE));
    directed.push_back(row(OP_DIV, MX, MN, 1, 0));
    directed.push_back(row(OP_DIV, MN, MN, MN, MN));
    directed.push_back(row(OP_DIV, 32'hFFFF_FFFF, 7, 3, 32'hFFFF_FFFD));
    directed.push_back(row(OP_NEG, MN, MX, 9, 9, 1, MX, 32'h8000_0001, 0, 0, 1));
    directed.push_back(row(OP_CMP, 7, 7, 7, 7, 1, 0, 0, 1, 0, 0));
    directed.push_back(row(OP_CMP, 7, 7, 8, 7, 1, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_CMP, MN, MX, MX, MN));
    directed.push_back(row(OP_NONE6, MX, MX, MX, MX, 1, 0, 0));
    directed.push_back(row(OP_NONE7, MN, 1, 1, 1, 1, 0, 0));
    foreach (directed[i]) send_item(directed[i].x, directed[i].typed, directed[i].want);
    drain();

    // Fill the pipe against a stalled output, then pause for the drain.
    long_hold = 1;
    burst = 1;
    for (int i = 0; i < 60; i++) send_item(random_operands(), 0, none);
    burst = 0;
    drain();

    foreach (tols[t]) begin
      write_tolerance(tols[t]);
      for (int i = 0; i < N_RANDOM / 5; i++) send_item(random_operands(), 0, none);
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
